>>> design/b2ds_pkg.sv
// ----------------------------------------------------------------------------
// b2ds_pkg
// Shared types and constants for the separable 3x3 binomial smoothing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package b2ds_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_ROW_LEN_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed widths of the control fields.
    localparam int ROW_W      = 16;
    localparam int LEN_CFG_W  = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Register values after reset.
    localparam int ROW_LENGTH_RESET = 1024;
    localparam int ROW_COUNT_RESET  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH = 1'b0,
        REG_ROW_COUNT  = 1'b1
    } b2ds_cfg_reg_t;

    // Position flags of an item, worked out when it is taken in.
    typedef struct packed {
        logic row_nz;
        logic row_one;
        logic col_nz;
        logic col_one;
        logic last_col;
        logic last_row;
    } b2ds_flags_t;

endpackage

`default_nettype wire

>>> design/binomial_2d_smoothing_unit.sv
// ----------------------------------------------------------------------------
// binomial_2d_smoothing_unit
// Separable (1 2 1)/4 x (1 2 1)/4 smoothing of a row-major sample stream with
// mirrored borders, two line memories of raw samples and a result queue.
// ----------------------------------------------------------------------------
// The result for row r-1, column c-1 is worked out from the item at row r,
// column c: the memories are read as it is taken in, then the sums go to the queue.
// Throughput: one item per cycle while m_ready holds and each item gives at
// most one; last-row items give up to two, row ends up to four, one per cycle.
// Reset: synchronous, active low; clears counters, registers and control state,
// but not the line memories, whose unwritten entries are never used.
`default_nettype none

module binomial_2d_smoothing_unit
    import b2ds_pkg::*;
#(
    parameter int MAX_ROW_LEN = MAX_ROW_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [CFG_DATA_W-1:0]             cfg_wdata,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_sample,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [SAMPLE_BITS+3:0]          m_smoothed_value,
    output logic [ROW_W-1:0]                       m_out_row,
    output logic [$clog2(MAX_ROW_LEN)-1:0]         m_out_column,
    output logic                                   m_grid_done
);

    localparam int COL_W = $clog2(MAX_ROW_LEN);
    localparam int VC_W  = SAMPLE_BITS + 2;
    localparam int OUT_W = SAMPLE_BITS + 4;
    localparam int RESET_LEN = (ROW_LENGTH_RESET > MAX_ROW_LEN) ? MAX_ROW_LEN
                                                                : ROW_LENGTH_RESET;
    localparam logic [COL_W-1:0] RESET_LEN_M1 = COL_W'(RESET_LEN - 1);
    localparam logic [ROW_W-1:0] RESET_CNT_M1 = ROW_W'(ROW_COUNT_RESET - 1);

    // ------------------------------------------------------------------
    // Configuration, kept as last column and last row index.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] len_m1_reg, len_m1_next;
    logic [ROW_W-1:0] cnt_m1_reg, cnt_m1_next;
    logic [31:0]      len_ext;
    logic [ROW_W-1:0] cnt_val;

    always_comb begin
        len_ext     = 32'(cfg_wdata[LEN_CFG_W-1:0]);
        cnt_val     = cfg_wdata[ROW_W-1:0];
        len_m1_next = len_m1_reg;
        cnt_m1_next = cnt_m1_reg;
        if (cfg_wen) begin
            case (cfg_index)
                REG_ROW_LENGTH: begin
                    if (len_ext < 32'd2) begin
                        len_m1_next = COL_W'(1);
                    end else if (len_ext > 32'(MAX_ROW_LEN)) begin
                        len_m1_next = COL_W'(MAX_ROW_LEN - 1);
                    end else begin
                        len_m1_next = COL_W'(len_ext - 32'd1);
                    end
                end
                REG_ROW_COUNT: begin
                    cnt_m1_next = (cnt_val < ROW_W'(2)) ? ROW_W'(1)
                                                        : cnt_val - ROW_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_m1_reg <= RESET_LEN_M1;
            cnt_m1_reg <= RESET_CNT_M1;
        end else begin
            len_m1_reg <= len_m1_next;
            cnt_m1_reg <= cnt_m1_next;
        end
    end

    // ------------------------------------------------------------------
    // Input side: position counters and line-memory read.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             in_fire;
    logic             in_last_col, in_last_row;
    b2ds_flags_t      in_flags;

    logic                      s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [ROW_W-1:0]          s1_row_reg;
    logic [COL_W-1:0]          s1_col_reg;
    b2ds_flags_t               s1_flags_reg;
    logic                      s1_adv;

    assign s_ready = !s1_valid_reg || s1_adv;
    assign in_fire = s_valid && s_ready;

    assign in_last_col = (col_reg >= len_m1_reg);
    assign in_last_row = (row_reg >= cnt_m1_reg);

    always_comb begin
        in_flags.row_nz   = (row_reg != '0);
        in_flags.row_one  = (row_reg == ROW_W'(1));
        in_flags.col_nz   = (col_reg != '0);
        in_flags.col_one  = (col_reg == COL_W'(1));
        in_flags.last_col = in_last_col;
        in_flags.last_row = in_last_row;

        col_next = col_reg;
        row_next = row_reg;
        if (in_fire) begin
            if (in_last_col) begin
                col_next = '0;
                row_next = in_last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_sample_reg <= s_sample;
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            s1_flags_reg  <= in_flags;
        end
    end

    // Line memories: one read when an item is taken in, one write when it
    // leaves the math stage. Two items in flight always sit in different
    // columns, and a column is written before the next item of that column
    // is read, so no forwarding is needed.
    logic signed [SAMPLE_BITS-1:0] prev_mem  [MAX_ROW_LEN];
    logic signed [SAMPLE_BITS-1:0] older_mem [MAX_ROW_LEN];
    logic signed [SAMPLE_BITS-1:0] p_rd_reg;
    logic signed [SAMPLE_BITS-1:0] o_rd_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p_rd_reg <= prev_mem[col_reg];
            o_rd_reg <= older_mem[col_reg];
        end
        if (s1_adv) begin
            older_mem[s1_col_reg] <= p_rd_reg;
            prev_mem[s1_col_reg]  <= s1_sample_reg;
        end
    end

    // ------------------------------------------------------------------
    // Math stage: vertical sums, then horizontal sums against the window.
    // Window entries 0 and 1 belong to the upper output row, 2 and 3 to the
    // last row, which is only smoothed while the last row streams in.
    // ------------------------------------------------------------------
    logic signed [VC_W-1:0]  w_reg [4];
    logic signed [VC_W-1:0]  p_x, o_x, s_x;
    logic signed [VC_W-1:0]  vc [2];
    logic signed [OUT_W-1:0] wa_x [2];
    logic signed [OUT_W-1:0] wb_x [2];
    logic signed [OUT_W-1:0] vc_x [2];
    logic signed [OUT_W-1:0] center_val [2];
    logic signed [OUT_W-1:0] edge_val [2];

    assign p_x = VC_W'(p_rd_reg);
    assign o_x = VC_W'(o_rd_reg);
    assign s_x = VC_W'(s1_sample_reg);

    always_comb begin
        // The first row mirrors its missing upper neighbour.
        vc[0] = s1_flags_reg.row_one ? (p_x <<< 1) + (s_x <<< 1)
                                     : o_x + (p_x <<< 1) + s_x;
        // The last row mirrors its missing lower neighbour.
        vc[1] = (p_x <<< 1) + (s_x <<< 1);
        for (int t = 0; t < 2; t++) begin
            wa_x[t] = OUT_W'(w_reg[2*t]);
            wb_x[t] = OUT_W'(w_reg[2*t+1]);
            vc_x[t] = OUT_W'(vc[t]);
            edge_val[t]   = (wb_x[t] <<< 1) + (vc_x[t] <<< 1);
            center_val[t] = s1_flags_reg.col_one ? edge_val[t]
                                                 : wa_x[t] + (wb_x[t] <<< 1) + vc_x[t];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                w_reg[i] <= '0;
            end
        end else if (s1_adv && s1_flags_reg.row_nz) begin
            w_reg[0] <= w_reg[1];
            w_reg[1] <= vc[0];
            if (s1_flags_reg.last_row) begin
                w_reg[2] <= w_reg[3];
                w_reg[3] <= vc[1];
            end
        end
    end

    // Results of one item, upper row first.
    logic [2:0]              ld_cnt;
    logic signed [OUT_W-1:0] ld_val  [4];
    logic [ROW_W-1:0]        ld_row  [4];
    logic [COL_W-1:0]        ld_col  [4];
    logic                    ld_done [4];
    logic [ROW_W-1:0]        up_row;
    logic [COL_W-1:0]        left_col;

    assign up_row   = s1_row_reg - ROW_W'(1);
    assign left_col = s1_col_reg - COL_W'(1);

    always_comb begin
        ld_cnt = 3'd0;
        for (int i = 0; i < 4; i++) begin
            ld_val[i]  = center_val[0];
            ld_row[i]  = up_row;
            ld_col[i]  = left_col;
            ld_done[i] = 1'b0;
        end
        if (s1_flags_reg.row_nz && s1_flags_reg.col_nz) begin
            ld_cnt = 3'd1;
            if (s1_flags_reg.last_col) begin
                ld_val[1] = edge_val[0];
                ld_col[1] = s1_col_reg;
                ld_cnt    = 3'd2;
                if (s1_flags_reg.last_row) begin
                    ld_val[2]  = center_val[1];
                    ld_row[2]  = s1_row_reg;
                    ld_val[3]  = edge_val[1];
                    ld_row[3]  = s1_row_reg;
                    ld_col[3]  = s1_col_reg;
                    ld_done[3] = 1'b1;
                    ld_cnt     = 3'd4;
                end
            end else if (s1_flags_reg.last_row) begin
                ld_val[1] = center_val[1];
                ld_row[1] = s1_row_reg;
                ld_cnt    = 3'd2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue: holds the results of one item and shifts them out.
    // ------------------------------------------------------------------
    logic [2:0]              q_cnt_reg, q_cnt_next;
    logic signed [OUT_W-1:0] q_val_reg  [4];
    logic [ROW_W-1:0]        q_row_reg  [4];
    logic [COL_W-1:0]        q_col_reg  [4];
    logic                    q_done_reg [4];
    logic                    out_fire;
    logic                    q_free;
    logic                    q_load;

    assign m_valid  = (q_cnt_reg != 3'd0);
    assign out_fire = m_valid && m_ready;
    assign q_free   = (q_cnt_reg == 3'd0) || ((q_cnt_reg == 3'd1) && m_ready);
    assign s1_adv   = s1_valid_reg && ((ld_cnt == 3'd0) || q_free);
    assign q_load   = s1_adv && (ld_cnt != 3'd0);

    always_comb begin
        q_cnt_next = q_cnt_reg;
        if (q_load) begin
            q_cnt_next = ld_cnt;
        end else if (out_fire) begin
            q_cnt_next = q_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= 3'd0;
        end else begin
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_load) begin
            for (int i = 0; i < 4; i++) begin
                q_val_reg[i]  <= ld_val[i];
                q_row_reg[i]  <= ld_row[i];
                q_col_reg[i]  <= ld_col[i];
                q_done_reg[i] <= ld_done[i];
            end
        end else if (out_fire) begin
            for (int i = 0; i < 3; i++) begin
                q_val_reg[i]  <= q_val_reg[i+1];
                q_row_reg[i]  <= q_row_reg[i+1];
                q_col_reg[i]  <= q_col_reg[i+1];
                q_done_reg[i] <= q_done_reg[i+1];
            end
        end
    end

    assign m_smoothed_value = q_val_reg[0];
    assign m_out_row        = q_row_reg[0];
    assign m_out_column     = q_col_reg[0];
    assign m_grid_done      = q_done_reg[0];

endmodule

`default_nettype wire

>>> sim/binomial_2d_smoothing_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binomial_2d_smoothing_checker
// Watches the configuration port and both item channels of the smoothing unit,
// keeps its own copy of the line stores, window sums and grid position, works
// out the smoothed points each accepted sample must produce and compares every
// delivered point field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module binomial_2d_smoothing_checker
    import b2ds_pkg::*;
(
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                cfg_wdata,
    input  wire logic                                 s_valid,
    input  wire logic                                 s_ready,
    input  wire logic signed [SAMPLE_BITS_DEF-1:0]    s_sample,
    input  wire logic                                 m_valid,
    input  wire logic                                 m_ready,
    input  wire logic signed [SAMPLE_BITS_DEF+3:0]    m_smoothed_value,
    input  wire logic [ROW_W-1:0]                     m_out_row,
    input  wire logic [$clog2(MAX_ROW_LEN_DEF)-1:0]   m_out_column,
    input  wire logic                                 m_grid_done,
    output int                                        mismatch_total,
    output int                                        points_outstanding,
    output logic                                      at_grid_start
);

    localparam int LINE_DEPTH = MAX_ROW_LEN_DEF;
    localparam int COL_W      = $clog2(LINE_DEPTH);

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF+3:0] value;
        logic [ROW_W-1:0]                  row;
        logic [COL_W-1:0]                  column;
        logic                              done;
    } smoothed_point_t;

    logic signed [SAMPLE_BITS_DEF-1:0] older_line [LINE_DEPTH];
    logic signed [SAMPLE_BITS_DEF-1:0] previous_line [LINE_DEPTH];
    // Vertical sums in units of 1/4: [0],[1] for the row above, [2],[3] for this row.
    int                    window_sum [4];
    logic [LEN_CFG_W-1:0]  row_length;
    logic [ROW_W-1:0]      row_count;
    int                    col_pos;
    int                    row_pos;
    smoothed_point_t       expected_points [$];
    int                    mismatch_count = 0;

    function automatic smoothed_point_t make_point(int sum, int row, int column, bit done);
        smoothed_point_t pt;
        pt.value  = sum[SAMPLE_BITS_DEF+3:0];
        pt.row    = row[ROW_W-1:0];
        pt.column = column[COL_W-1:0];
        pt.done   = done;
        return pt;
    endfunction

    task automatic smooth_sample(input logic signed [SAMPLE_BITS_DEF-1:0] smp);
        smoothed_point_t pts [4];
        int vert [2];
        int len_eff, cnt_eff, above, above2, rows, n, t;
        bit last_col, last_row;
        len_eff  = (row_length < 2) ? 2 : ((row_length > LINE_DEPTH) ? LINE_DEPTH : row_length);
        cnt_eff  = (row_count < 2) ? 2 : row_count;
        last_col = col_pos >= len_eff - 1;
        last_row = row_pos >= cnt_eff - 1;
        above    = int'(previous_line[col_pos]);
        above2   = int'(older_line[col_pos]);
        n        = 0;
        if (row_pos >= 1) begin
            rows    = last_row ? 2 : 1;
            // Row 1 has no row above its upper neighbour, so that neighbour is mirrored.
            vert[0] = (row_pos == 1) ? 2 * above + 2 * smp : above2 + 2 * above + smp;
            vert[1] = 2 * above + 2 * smp;
            for (t = 0; t < rows; t++) begin
                if (col_pos >= 1) begin
                    pts[n] = make_point((col_pos == 1)
                                 ? 2 * window_sum[2*t+1] + 2 * vert[t]
                                 : window_sum[2*t] + 2 * window_sum[2*t+1] + vert[t],
                             row_pos - 1 + t, col_pos - 1, 1'b0);
                    n++;
                end
                window_sum[2*t]   = window_sum[2*t+1];
                window_sum[2*t+1] = vert[t];
            end
            if (last_col && col_pos >= 1) begin
                for (t = 0; t < rows; t++) begin
                    pts[n] = make_point(2 * window_sum[2*t] + 2 * window_sum[2*t+1],
                                        row_pos - 1 + t, col_pos,
                                        last_row && t == rows - 1);
                    n++;
                end
            end
        end
        // A row end on the last row gives four points; the upper row goes out first.
        if (n == 4) begin
            expected_points.push_back(pts[0]);
            expected_points.push_back(pts[2]);
            expected_points.push_back(pts[1]);
            expected_points.push_back(pts[3]);
        end else begin
            for (t = 0; t < n; t++)
                expected_points.push_back(pts[t]);
        end
        older_line[col_pos]    = previous_line[col_pos];
        previous_line[col_pos] = smp;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic note_mismatch(input string field, input longint want, input longint got);
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    task automatic check_point(input smoothed_point_t got);
        smoothed_point_t want;
        if (expected_points.size() == 0) begin
            $display("%0t: unexpected item: value %0d row %0d column %0d done %0d",
                     $time, $signed(got.value), got.row, got.column, got.done);
            mismatch_count++;
        end else begin
            want = expected_points.pop_front();
            if (got.value !== want.value)
                note_mismatch("smoothed_value", $signed(want.value), $signed(got.value));
            if (got.row !== want.row)
                note_mismatch("out_row", want.row, got.row);
            if (got.column !== want.column)
                note_mismatch("out_column", want.column, got.column);
            if (got.done !== want.done)
                note_mismatch("grid_done", want.done, got.done);
        end
    endtask

    always @(posedge aclk) begin : monitor
        smoothed_point_t seen;
        int k;
        if (!aresetn) begin
            row_length = LEN_CFG_W'(ROW_LENGTH_RESET);
            row_count  = ROW_W'(ROW_COUNT_RESET);
            col_pos    = 0;
            row_pos    = 0;
            for (k = 0; k < 4; k++)
                window_sum[k] = 0;
        end else begin
            if (cfg_wen) begin
                case (b2ds_cfg_reg_t'(cfg_index))
                    REG_ROW_LENGTH: row_length = cfg_wdata[LEN_CFG_W-1:0];
                    REG_ROW_COUNT:  row_count  = cfg_wdata[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                smooth_sample(s_sample);
            if (m_valid && m_ready) begin
                seen.value  = m_smoothed_value;
                seen.row    = m_out_row;
                seen.column = m_out_column;
                seen.done   = m_grid_done;
                check_point(seen);
            end
        end
        mismatch_total     <= mismatch_count;
        points_outstanding <= expected_points.size();
        at_grid_start      <= (col_pos == 0) && (row_pos == 0);
    end

endmodule

>>> sim/binomial_2d_smoothing_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binomial_2d_smoothing_unit_test
// Drives the smoothing unit with short directed grids at the sample and shape
// extremes, then random grids of varied shape, including shape changes in the
// middle of a grid, a very tall grid cut short and one grid started at the
// widest row and cut short. The sender works in bursts and the receiver stalls
// in changing patterns; a separate checker predicts and compares every point.
// ----------------------------------------------------------------------------
module binomial_2d_smoothing_unit_test;
    import b2ds_pkg::*;

    localparam int RANDOM_ITEMS   = 320;
    localparam int HOLD_OFF       = 10;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        READY_ALWAYS,
        READY_SPARSE_STALLS,
        READY_PERIODIC,
        READY_HEAVY_STALLS
    } ready_pattern_t;

    logic                                        aclk      = 1'b0;
    logic                                        aresetn   = 1'b0;
    logic                                        cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]                        cfg_index = REG_ROW_LENGTH;
    logic [CFG_DATA_W-1:0]                       cfg_wdata = '0;
    logic                                        s_valid   = 1'b0;
    logic                                        s_ready;
    logic signed [SAMPLE_BITS_DEF-1:0]           s_sample  = '0;
    logic                                        m_valid;
    logic                                        m_ready   = 1'b0;
    logic signed [SAMPLE_BITS_DEF+3:0]           m_smoothed_value;
    logic [ROW_W-1:0]                            m_out_row;
    logic [$clog2(MAX_ROW_LEN_DEF)-1:0]          m_out_column;
    logic                                        m_grid_done;

    int             mismatch_total;
    int             points_outstanding;
    logic           at_grid_start;
    int             items_sent = 0;
    int             burst_left = 0;
    int             len_eff    = ROW_LENGTH_RESET;
    int             cnt_eff    = ROW_COUNT_RESET;
    bit             steady     = 1'b0;
    ready_pattern_t ready_pattern;
    int             pattern_cycles = 0;
    int             stall_left     = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    binomial_2d_smoothing_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_smoothed_value (m_smoothed_value),
        .m_out_row        (m_out_row),
        .m_out_column     (m_out_column),
        .m_grid_done      (m_grid_done)
    );

    binomial_2d_smoothing_checker smoothing_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wen            (cfg_wen),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample           (s_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_smoothed_value   (m_smoothed_value),
        .m_out_row          (m_out_row),
        .m_out_column       (m_out_column),
        .m_grid_done        (m_grid_done),
        .mismatch_total     (mismatch_total),
        .points_outstanding (points_outstanding),
        .at_grid_start      (at_grid_start)
    );

    // The receiver switches between randomly chosen stall patterns.
    always @(negedge aclk) begin
        if (pattern_cycles == 0) begin
            ready_pattern  = ready_pattern_t'($urandom_range(0, 3));
            pattern_cycles = $urandom_range(50, 300);
        end
        pattern_cycles--;
        if (stall_left == 0) begin
            case (ready_pattern)
                READY_ALWAYS:        stall_left = 0;
                READY_SPARSE_STALLS: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                READY_PERIODIC:      if (pattern_cycles % 5 == 0) stall_left = 2;
                default:             if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 8);
            endcase
        end
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_BITS_DEF'(int'($urandom_range(0, 6)) - 3);
            default: return SAMPLE_BITS_DEF'($urandom());
        endcase
    endfunction

    function automatic int random_length();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1);
            1:       return $urandom_range(13, 40);
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    function automatic int random_count();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, with valid still high.
    task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        do @(negedge aclk); while (points_outstanding != 0);
        // Items on the first row give no results and may still be in flight.
        repeat (HOLD_OFF) @(negedge aclk);
    endtask

    task automatic write_register(input b2ds_cfg_reg_t index, input int value);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
        if (index == REG_ROW_LENGTH)
            len_eff = (value < 2) ? 2 : ((value > MAX_ROW_LEN_DEF) ? MAX_ROW_LEN_DEF : value);
        else
            cnt_eff = (value < 2) ? 2 : value;
    endtask

    task automatic set_shape(input int length, input int count);
        if ($urandom_range(0, 1)) begin
            write_register(REG_ROW_LENGTH, length);
            write_register(REG_ROW_COUNT, count);
        end else begin
            write_register(REG_ROW_COUNT, count);
            write_register(REG_ROW_LENGTH, length);
        end
    endtask

    task automatic send_grids(input int grids);
        repeat (grids * len_eff * cnt_eff) send_sample(random_sample());
    endtask

    // The row length is never raised mid-grid, so every line entry read
    // afterwards was written earlier in the same grid.
    task automatic reshape_mid_grid(input bit force_count);
        int choice;
        choice = $urandom_range(0, 2);
        settle_block();
        if (choice != 1 || force_count)
            write_register(REG_ROW_COUNT, random_count());
        if (choice != 0)
            write_register(REG_ROW_LENGTH, $urandom_range(0, len_eff));
        while (!at_grid_start)
            send_sample(random_sample());
    endtask

    task automatic random_phase();
        bit tall;
        settle_block();
        tall   = ($urandom_range(0, 5) == 0);
        steady = ($urandom_range(0, 3) == 0);
        set_shape(random_length(), tall ? 16'hFFFF : random_count());
        if (tall) begin
            repeat ($urandom_range(2, 4) * len_eff + $urandom_range(0, len_eff - 1))
                send_sample(random_sample());
            reshape_mid_grid(1'b1);
        end else if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, len_eff * cnt_eff - 1))
                send_sample(random_sample());
            reshape_mid_grid(1'b0);
        end else begin
            send_grids($urandom_range(1, 2));
        end
    endtask

    initial begin : stimulus
        int random_start;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Smallest grid, checkerboard of the sample extremes.
        set_shape(2, 2);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        // Three by three: interior point, mirrored edges and a row end on the last row.
        settle_block();
        set_shape(3, 3);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        // Register values below the minimum clamp to a two by two grid; these
        // give the largest and the smallest smoothed value.
        settle_block();
        set_shape(0, 0);
        repeat (4) send_sample(16'sh7FFF);
        settle_block();
        set_shape(1, 1);
        repeat (4) send_sample(16'sh8000);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
            random_phase();

        // The widest row, set either exactly or clamped from above; a shorter
        // row length partway along the first row then ends that row early.
        settle_block();
        steady = 1'b0;
        set_shape($urandom_range(0, 1) ? MAX_ROW_LEN_DEF : 2047, 1);
        repeat ($urandom_range(16, 40)) send_sample(random_sample());
        settle_block();
        write_register(REG_ROW_LENGTH, $urandom_range(2, 12));
        while (!at_grid_start)
            send_sample(random_sample());

        settle_block();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_total == 0 && points_outstanding == 0) begin
            $display("PASS binomial_2d_smoothing_unit");
        end else begin
            $display("FAIL binomial_2d_smoothing_unit");
        end
        $finish;
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL binomial_2d_smoothing_unit");
        $finish;
    end

endmodule
